FILE: rtl/lpr_pkg.sv
// Shared widths and reset values for the LRU page replacement block.
package lpr_pkg;

  // Field widths of the transactions and the configuration register
  localparam int unsigned PAGE_W = 4;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned TS_W   = 32;

  // Frames in use after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

endpackage

FILE: rtl/lpr_if.sv
// Valid/ready channel interfaces for page accesses and replacement results.
interface lpr_in_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lpr_out_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] frame_slot;
  logic              evicted_valid;
  logic [PAGE_W-1:0] evicted_page;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                  input evicted_page, output ready);
endinterface

FILE: rtl/lpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/lru_page_replacement.sv
// LRU page replacement unit: top level with its scan sequencer.
//
// Usage: each transaction on in_ch carries one page access; each access
// yields exactly one transaction on out_ch (hit flag, frame used, and the
// displaced page on a fault). cfg_we/cfg_wdata set the number of frames the
// policy may fill; write it only while the block is idle.
// From input acceptance, a hit goes through the look-up and done states to
// the result register; a fault into an empty frame goes through look-up,
// place and done; a fault with eviction adds a scan over every active frame
// between look-up and place. Input is taken one access at a time: a new
// access is accepted only once the last result has left the done state.
// The eviction scan reads one frame
// timestamp per cycle from the frame RAM and compares it against the running
// minimum in one 32-bit comparator.
// A finished result waits in the output register while the next access is
// taken; if out_ch stalls, the next access completes its work and then holds
// until the output register frees up.
// Reset (rst_n low, synchronous) empties every frame, clears all resident
// marks and the access counter, and sets frames in use to 3. No clearing
// pass is needed: RAM entries are only read once written.
module lru_page_replacement #(
  parameter int unsigned PAGES  = 16,
  parameter int unsigned FRAMES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lpr_in_if.sink                    in_ch,
  lpr_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_wdata
);
  import lpr_pkg::*;

  localparam int unsigned PW = $clog2(PAGES);
  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned LW = $clog2(FRAMES + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_r, cfg_nxt;
  logic [TS_W-1:0]   cnt_r, cnt_nxt;
  logic [FRAMES-1:0] filled_r, filled_nxt;
  logic [PAGES-1:0]  resident_r, resident_nxt;
  logic [LW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working payload
  logic [PW-1:0]     page_r, page_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic [FW-1:0]     slot_r, slot_nxt;
  logic [PW-1:0]     victim_r, victim_nxt;
  logic [TS_W-1:0]   min_r, min_nxt;
  logic              evict_r, evict_nxt;
  logic              hit_r, hit_nxt;
  logic [FW-1:0]     rd_idx_r, rd_idx_nxt;

  // Output register payload
  logic              out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_ev_r, out_ev_nxt;
  logic [PAGE_W-1:0] out_evpage_r, out_evpage_nxt;

  // RAM ports
  logic              ts_we;
  logic [FW-1:0]     ts_waddr;
  logic [TS_W-1:0]   ts_wdata;
  logic [TS_W-1:0]   ts_rdata;
  logic              fp_we;
  logic [PW-1:0]     fp_rdata;
  logic              pf_we;
  logic [FW-1:0]     pf_rdata;
  logic [FW-1:0]     scan_addr;

  // Derived values
  logic [PW-1:0]     page_red;
  logic [LW-1:0]     limit;
  logic              found_empty;
  logic [FW-1:0]     empty_slot;
  logic              issue;
  logic [FW+2:0]     slot_ext;
  logic [PW+3:0]     victim_ext;

  // Reduce the incoming page modulo PAGES by restoring subtraction
  always_comb begin
    logic [12:0] rem;
    rem = 13'(in_ch.page_number);
    for (int k = 3; k >= 0; k--) begin
      if (rem >= 13'(PAGES << k)) begin
        rem = rem - 13'(PAGES << k);
      end
    end
    page_red = rem[PW-1:0];
  end

  // Clamp the frame count to 1..FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      limit = LW'(1);
    end else if (32'(cfg_r) > FRAMES) begin
      limit = LW'(FRAMES);
    end else begin
      limit = LW'(cfg_r);
    end
  end

  // Find the lowest empty frame below the limit
  always_comb begin
    found_empty = 1'b0;
    empty_slot  = '0;
    for (int j = FRAMES - 1; j >= 0; j--) begin
      if (!filled_r[j] && (j < int'(limit))) begin
        found_empty = 1'b1;
        empty_slot  = FW'(j);
      end
    end
  end

  assign issue      = (scan_idx_r < limit);
  assign scan_addr  = scan_idx_r[FW-1:0];
  assign slot_ext   = {3'b000, slot_r};
  assign victim_ext = {4'b0000, victim_r};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cfg_nxt        = cfg_r;
    cnt_nxt        = cnt_r;
    filled_nxt     = filled_r;
    resident_nxt   = resident_r;
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r;
    page_nxt       = page_r;
    ts_nxt         = ts_r;
    slot_nxt       = slot_r;
    victim_nxt     = victim_r;
    min_nxt        = min_r;
    evict_nxt      = evict_r;
    hit_nxt        = hit_r;
    rd_idx_nxt     = rd_idx_r;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_ev_nxt     = out_ev_r;
    out_evpage_nxt = out_evpage_r;
    ts_we          = 1'b0;
    ts_waddr       = slot_r;
    ts_wdata       = ts_r;
    fp_we          = 1'b0;
    pf_we          = 1'b0;

    if (cfg_we) begin
      cfg_nxt = cfg_wdata;
    end

    // Drop the result once taken
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Latch the access and stamp it with the saturating counter
        if (in_ch.valid) begin
          page_nxt  = page_red;
          ts_nxt    = cnt_r;
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + TS_W'(1);
          end
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        hit_nxt = resident_r[page_r];
        if (resident_r[page_r]) begin
          // Hit: refresh the timestamp of the frame holding the page
          slot_nxt  = pf_rdata;
          ts_we     = 1'b1;
          ts_waddr  = pf_rdata;
          evict_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (found_empty) begin
          slot_nxt  = empty_slot;
          evict_nxt = 1'b0;
          state_nxt = S_PLACE;
        end else begin
          evict_nxt    = 1'b1;
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one frame read per cycle, compare the one returning
        if (issue) begin
          scan_idx_nxt = scan_idx_r + LW'(1);
        end
        rd_pend_nxt = issue;
        rd_idx_nxt  = scan_addr;
        if (rd_pend_r) begin
          if ((rd_idx_r == '0) || (ts_rdata < min_r)) begin
            min_nxt    = ts_rdata;
            slot_nxt   = rd_idx_r;
            victim_nxt = fp_rdata;
          end
          if (LW'(rd_idx_r) == (limit - LW'(1))) begin
            state_nxt = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        // Install the page in the chosen frame
        ts_we  = 1'b1;
        fp_we  = 1'b1;
        pf_we  = 1'b1;
        filled_nxt[slot_r] = 1'b1;
        if (evict_r) begin
          resident_nxt[victim_r] = 1'b0;
        end
        resident_nxt[page_r] = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register when it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = hit_r;
          out_slot_nxt   = slot_ext[SLOT_W-1:0];
          out_ev_nxt     = evict_r;
          out_evpage_nxt = evict_r ? victim_ext[PAGE_W-1:0] : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_RESET;
      cnt_r       <= '0;
      filled_r    <= '0;
      resident_r  <= '0;
      scan_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      cnt_r       <= cnt_nxt;
      filled_r    <= filled_nxt;
      resident_r  <= resident_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    ts_r         <= ts_nxt;
    slot_r       <= slot_nxt;
    victim_r     <= victim_nxt;
    min_r        <= min_nxt;
    evict_r      <= evict_nxt;
    hit_r        <= hit_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ev_r     <= out_ev_nxt;
    out_evpage_r <= out_evpage_nxt;
  end

  // Last-use timestamp of the page held in each frame
  lpr_ram #(.WIDTH(TS_W), .DEPTH(FRAMES)) u_ts_ram (
    .clk   (clk),
    .we    (ts_we),
    .waddr (ts_waddr),
    .wdata (ts_wdata),
    .raddr (scan_addr),
    .rdata (ts_rdata)
  );

  // Page held in each frame
  lpr_ram #(.WIDTH(PW), .DEPTH(FRAMES)) u_fpage_ram (
    .clk   (clk),
    .we    (fp_we),
    .waddr (slot_r),
    .wdata (page_r),
    .raddr (scan_addr),
    .rdata (fp_rdata)
  );

  // Frame holding each resident page
  lpr_ram #(.WIDTH(FW), .DEPTH(PAGES)) u_pframe_ram (
    .clk   (clk),
    .we    (pf_we),
    .waddr (page_r),
    .wdata (slot_r),
    .raddr (page_red),
    .rdata (pf_rdata)
  );

  // Channel outputs
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame_slot    = out_slot_r;
  assign out_ch.evicted_valid = out_ev_r;
  assign out_ch.evicted_page  = out_evpage_r;

endmodule

FILE: rtl/lpr_checker.sv
// Port-level checker for the LRU page replacement block, bound to its top level.
module lpr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_hit,
  input logic [lpr_pkg::SLOT_W-1:0] out_frame_slot,
  input logic                       out_evicted_valid,
  input logic [lpr_pkg::PAGE_W-1:0] out_evicted_page
);
  import lpr_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
    $stable(out_frame_slot) && $stable(out_evicted_valid) && $stable(out_evicted_page))
    else $error("result changed while stalled");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("hit reported an eviction");

  // Without an eviction the evicted page reads zero
  a_evpage_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> (out_evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  // One access in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new access taken while one is in flight");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hit           (out_ch.hit),
  .out_frame_slot    (out_ch.frame_slot),
  .out_evicted_valid (out_ch.evicted_valid),
  .out_evicted_page  (out_ch.evicted_page)
);
